>>> rtl/nps_pkg.sv
// ----------------------------------------------------------------------------
// nps_pkg
// Shared constants, control types and microcode program of the nonlinear
// preamp shaper.
// ----------------------------------------------------------------------------
package nps_pkg;

  localparam int POLY_TERMS_DEF  = 4;
  localparam int MAX_DELAY_DEF   = 64;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int STATE_BITS_DEF  = 32;

  localparam int OUT_BITS        = 32;
  localparam int COEF_BITS       = 16;
  localparam int COEF_SHIFT      = 4;
  localparam int Q_FRAC          = 16;
  localparam int CFG_IDX_BITS    = 3;
  localparam int CFG_DATA_BITS   = 64;
  localparam int DELAY_BITS      = 7;
  localparam int TERM_BITS       = 2;
  localparam int PC_BITS         = 6;
  localparam int NUM_POLY        = 6;

  localparam logic [CFG_IDX_BITS-1:0] REG_DELAY_BINS = 3'd6;

  // values match the configuration register indexes
  typedef enum logic [2:0] {
    POLY_IN, POLY_DIFF, POLY_DECAY, POLY_OS, POLY_OD, POLY_OO
  } poly_sel_t;

  typedef enum logic [2:0] {
    OP_IDLE, OP_XLOAD, OP_LOAD, OP_MLO, OP_MHI, OP_FIN, OP_USE, OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    ARG_CS, ARG_X, ARG_XMD, ARG_DEC, ARG_DD, ARG_OL
  } arg_t;

  typedef enum logic [2:0] {
    ACT_DEC, ACT_CS, ACT_DS, ACT_OS, ACT_OD, ACT_OO
  } act_t;

  typedef enum logic [2:0] {
    COND_NEXT, COND_ALWAYS, COND_NACC, COND_INACT, COND_DONE, COND_MORE
  } cond_t;

  typedef logic [PC_BITS-1:0] pc_t;

  typedef struct packed {
    op_t       op;
    arg_t      arg;
    poly_sel_t poly;
    act_t      act;
    cond_t     cond;
    pc_t       target;
  } uword_t;

  typedef struct packed {
    logic accept;
    logic active;
    logic out_busy;
  } nps_stat_t;

  localparam pc_t PC_IDLE  = 6'd0;
  localparam pc_t PC_XLOAD = 6'd1;
  localparam pc_t PC_DECAY = 6'd2;
  localparam pc_t PC_IN    = 6'd7;
  localparam pc_t PC_DIFF  = 6'd12;
  localparam pc_t PC_OS    = 6'd17;
  localparam pc_t PC_OD    = 6'd22;
  localparam pc_t PC_OO    = 6'd27;
  localparam pc_t PC_EMIT  = 6'd32;

  // offsets inside one polynomial block
  localparam pc_t OFS_MLO = 6'd1;
  localparam pc_t OFS_MHI = 6'd2;
  localparam pc_t OFS_FIN = 6'd3;
  localparam pc_t OFS_USE = 6'd4;

  function automatic uword_t uw(op_t op, arg_t arg, poly_sel_t poly, act_t act,
                                cond_t cond, pc_t target);
    uword_t w;
    w.op     = op;
    w.arg    = arg;
    w.poly   = poly;
    w.act    = act;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  function automatic uword_t ucode_rom(pc_t pc);
    uword_t w;
    case (pc)
      PC_IDLE:            w = uw(OP_IDLE,  ARG_CS,  POLY_IN,    ACT_DEC, COND_NACC,  PC_IDLE);
      PC_XLOAD:           w = uw(OP_XLOAD, ARG_CS,  POLY_IN,    ACT_DEC, COND_INACT, PC_EMIT);
      // decay = P_decay(charge)
      PC_DECAY:           w = uw(OP_LOAD,  ARG_CS,  POLY_DECAY, ACT_DEC, COND_NEXT,  PC_IDLE);
      PC_DECAY + OFS_MLO: w = uw(OP_MLO,   ARG_CS,  POLY_DECAY, ACT_DEC, COND_DONE,
                                 PC_DECAY + OFS_USE);
      PC_DECAY + OFS_MHI: w = uw(OP_MHI,   ARG_CS,  POLY_DECAY, ACT_DEC, COND_NEXT,  PC_IDLE);
      PC_DECAY + OFS_FIN: w = uw(OP_FIN,   ARG_CS,  POLY_DECAY, ACT_DEC, COND_MORE,
                                 PC_DECAY + OFS_MLO);
      PC_DECAY + OFS_USE: w = uw(OP_USE,   ARG_CS,  POLY_DECAY, ACT_DEC, COND_NEXT,  PC_IDLE);
      // charge update
      PC_IN:              w = uw(OP_LOAD,  ARG_X,   POLY_IN,    ACT_CS,  COND_NEXT,  PC_IDLE);
      PC_IN + OFS_MLO:    w = uw(OP_MLO,   ARG_X,   POLY_IN,    ACT_CS,  COND_DONE,
                                 PC_IN + OFS_USE);
      PC_IN + OFS_MHI:    w = uw(OP_MHI,   ARG_X,   POLY_IN,    ACT_CS,  COND_NEXT,  PC_IDLE);
      PC_IN + OFS_FIN:    w = uw(OP_FIN,   ARG_X,   POLY_IN,    ACT_CS,  COND_MORE,
                                 PC_IN + OFS_MLO);
      PC_IN + OFS_USE:    w = uw(OP_USE,   ARG_X,   POLY_IN,    ACT_CS,  COND_NEXT,  PC_IDLE);
      // diff update
      PC_DIFF:            w = uw(OP_LOAD,  ARG_XMD, POLY_DIFF,  ACT_DS,  COND_NEXT,  PC_IDLE);
      PC_DIFF + OFS_MLO:  w = uw(OP_MLO,   ARG_XMD, POLY_DIFF,  ACT_DS,  COND_DONE,
                                 PC_DIFF + OFS_USE);
      PC_DIFF + OFS_MHI:  w = uw(OP_MHI,   ARG_XMD, POLY_DIFF,  ACT_DS,  COND_NEXT,  PC_IDLE);
      PC_DIFF + OFS_FIN:  w = uw(OP_FIN,   ARG_XMD, POLY_DIFF,  ACT_DS,  COND_MORE,
                                 PC_DIFF + OFS_MLO);
      PC_DIFF + OFS_USE:  w = uw(OP_USE,   ARG_XMD, POLY_DIFF,  ACT_DS,  COND_NEXT,  PC_IDLE);
      // output terms
      PC_OS:              w = uw(OP_LOAD,  ARG_DEC, POLY_OS,    ACT_OS,  COND_NEXT,  PC_IDLE);
      PC_OS + OFS_MLO:    w = uw(OP_MLO,   ARG_DEC, POLY_OS,    ACT_OS,  COND_DONE,
                                 PC_OS + OFS_USE);
      PC_OS + OFS_MHI:    w = uw(OP_MHI,   ARG_DEC, POLY_OS,    ACT_OS,  COND_NEXT,  PC_IDLE);
      PC_OS + OFS_FIN:    w = uw(OP_FIN,   ARG_DEC, POLY_OS,    ACT_OS,  COND_MORE,
                                 PC_OS + OFS_MLO);
      PC_OS + OFS_USE:    w = uw(OP_USE,   ARG_DEC, POLY_OS,    ACT_OS,  COND_NEXT,  PC_IDLE);
      PC_OD:              w = uw(OP_LOAD,  ARG_DD,  POLY_OD,    ACT_OD,  COND_NEXT,  PC_IDLE);
      PC_OD + OFS_MLO:    w = uw(OP_MLO,   ARG_DD,  POLY_OD,    ACT_OD,  COND_DONE,
                                 PC_OD + OFS_USE);
      PC_OD + OFS_MHI:    w = uw(OP_MHI,   ARG_DD,  POLY_OD,    ACT_OD,  COND_NEXT,  PC_IDLE);
      PC_OD + OFS_FIN:    w = uw(OP_FIN,   ARG_DD,  POLY_OD,    ACT_OD,  COND_MORE,
                                 PC_OD + OFS_MLO);
      PC_OD + OFS_USE:    w = uw(OP_USE,   ARG_DD,  POLY_OD,    ACT_OD,  COND_NEXT,  PC_IDLE);
      PC_OO:              w = uw(OP_LOAD,  ARG_OL,  POLY_OO,    ACT_OO,  COND_NEXT,  PC_IDLE);
      PC_OO + OFS_MLO:    w = uw(OP_MLO,   ARG_OL,  POLY_OO,    ACT_OO,  COND_DONE,
                                 PC_OO + OFS_USE);
      PC_OO + OFS_MHI:    w = uw(OP_MHI,   ARG_OL,  POLY_OO,    ACT_OO,  COND_NEXT,  PC_IDLE);
      PC_OO + OFS_FIN:    w = uw(OP_FIN,   ARG_OL,  POLY_OO,    ACT_OO,  COND_MORE,
                                 PC_OO + OFS_MLO);
      PC_OO + OFS_USE:    w = uw(OP_USE,   ARG_OL,  POLY_OO,    ACT_OO,  COND_NEXT,  PC_IDLE);
      PC_EMIT:            w = uw(OP_EMIT,  ARG_CS,  POLY_IN,    ACT_DEC, COND_ALWAYS, PC_IDLE);
      default:            w = uw(OP_IDLE,  ARG_CS,  POLY_IN,    ACT_DEC, COND_ALWAYS, PC_IDLE);
    endcase
    return w;
  endfunction

endpackage

>>> rtl/nps_in_if.sv
// ----------------------------------------------------------------------------
// nps_in_if
// Input sample channel: valid/ready with sample and start-of-signal flag.
// ----------------------------------------------------------------------------
interface nps_in_if import nps_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          first_sample;

  modport source (output valid, sample, first_sample, input ready);
  modport sink   (input valid, sample, first_sample, output ready);
endinterface

>>> rtl/nps_out_if.sv
// ----------------------------------------------------------------------------
// nps_out_if
// Result channel: valid/ready with the output voltage sample.
// ----------------------------------------------------------------------------
interface nps_out_if import nps_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] voltage;

  modport source (output valid, voltage, input ready);
  modport sink   (input valid, voltage, output ready);
endinterface

>>> rtl/nps_cfg_if.sv
// ----------------------------------------------------------------------------
// nps_cfg_if
// Configuration write channel: valid/ready with register index and data.
// ----------------------------------------------------------------------------
interface nps_cfg_if import nps_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/nps_ram.sv
// ----------------------------------------------------------------------------
// nps_ram
// Generic single-write, single-read RAM with registered, read-first output.
// ----------------------------------------------------------------------------
module nps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

>>> rtl/nps_seq.sv
// ----------------------------------------------------------------------------
// nps_seq
// Microcode sequencer: step counter, program table fetch, Horner term
// counter and conditional jumps.
// ----------------------------------------------------------------------------
module nps_seq import nps_pkg::*; #(
  parameter int POLY_TERMS = POLY_TERMS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  nps_stat_t            stat,
  output uword_t               ctl,
  output logic [TERM_BITS-1:0] cidx
);

  localparam logic [TERM_BITS-1:0] TOP_TERM = TERM_BITS'(POLY_TERMS - 1);

  pc_t                  pc_r, pc_nxt;
  logic [TERM_BITS-1:0] k_r, k_nxt;
  logic                 jump;

  assign ctl  = ucode_rom(pc_r);
  assign cidx = (ctl.op == OP_LOAD) ? TOP_TERM : k_r - TERM_BITS'(1);

  always_comb begin
    case (ctl.cond)
      COND_NEXT:   jump = 1'b0;
      COND_ALWAYS: jump = 1'b1;
      COND_NACC:   jump = !stat.accept;
      COND_INACT:  jump = !stat.active;
      COND_DONE:   jump = (k_r == '0);
      COND_MORE:   jump = (k_r > TERM_BITS'(1));
      default:     jump = 1'b0;
    endcase
  end

  always_comb begin
    if (ctl.op == OP_EMIT && stat.out_busy) begin
      pc_nxt = pc_r;
    end else if (jump) begin
      pc_nxt = ctl.target;
    end else begin
      pc_nxt = pc_r + pc_t'(1);
    end
  end

  always_comb begin
    case (ctl.op)
      OP_LOAD: k_nxt = TOP_TERM;
      OP_FIN:  k_nxt = k_r - TERM_BITS'(1);
      default: k_nxt = k_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
      k_r  <= '0;
    end else begin
      pc_r <= pc_nxt;
      k_r  <= k_nxt;
    end
  end

endmodule

>>> rtl/nonlinear_preamp_shaper_top.sv
// ----------------------------------------------------------------------------
// nonlinear_preamp_shaper_top
// Nonlinear preamp shaper: delayed input drives six Horner polynomials in
// Q16.16 fixed point that update charge, diff and output states.
//
// Usage:
//   in_ch  : one beat per input sample (sample, first_sample).
//   out_ch : one beat per input beat, the voltage in Q16.16.
//   cfg_ch : register writes, always ready; write only while the block is idle.
// Each active item runs a microcode program on one shared multiplier; each
// Horner step is a low partial product, a high partial product and a
// truncate/saturate/add. The block takes no new input beat while an item is
// in work; it is ready again in the cycle in which the output beat becomes
// valid. Leading items of a signal go from XLOAD straight to EMIT and give
// a zero beat. The delay line is a RAM, one write and one read per item. A
// stalled receiver holds the result register; the block then waits at its
// final step and takes no new input until the beat is taken.
// Reset clears the states and coefficient registers and sets delay_bins to 1;
// the delay line needs no clearing.
// ----------------------------------------------------------------------------
module nonlinear_preamp_shaper_top import nps_pkg::*; #(
  parameter int POLY_TERMS  = POLY_TERMS_DEF,
  parameter int MAX_DELAY   = MAX_DELAY_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int STATE_BITS  = STATE_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  nps_in_if.sink     in_ch,
  nps_out_if.source  out_ch,
  nps_cfg_if.sink    cfg_ch
);

  localparam int SB   = STATE_BITS;
  localparam int SW   = SB + 2;
  localparam int H    = SB / 2;
  localparam int RW   = 2 * SB - Q_FRAC;
  localparam int AW   = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int CW   = $clog2(MAX_DELAY + 1);
  localparam int DW   = (CW > DELAY_BITS) ? CW : DELAY_BITS;
  localparam int PW   = ((DW > AW) ? DW : AW) + 1;
  localparam int SH_L = (SAMPLE_BITS <= 17) ? 17 - SAMPLE_BITS : 0;
  localparam int SH_R = (SAMPLE_BITS > 17) ? SAMPLE_BITS - 17 : 0;
  localparam int XW   = (SB > OUT_BITS) ? SB : OUT_BITS;

  function automatic logic signed [SB-1:0] sat_s(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] hi;
    logic signed [SW-1:0] lo;
    hi = {3'b000, {(SB-1){1'b1}}};
    lo = {3'b111, {(SB-1){1'b0}}};
    if (v > hi) begin
      return hi[SB-1:0];
    end else if (v < lo) begin
      return lo[SB-1:0];
    end
    return v[SB-1:0];
  endfunction

  function automatic logic [SB-1:0] mag_s(input logic signed [SB-1:0] v);
    logic [SB-1:0] m;
    m = v;
    if (v[SB-1]) begin
      m = ~m + SB'(1);
    end
    return m;
  endfunction

  uword_t               ctl;
  logic [TERM_BITS-1:0] cidx;
  nps_stat_t            stat;

  logic accept, active, out_busy;

  // configuration
  logic [CFG_DATA_BITS-1:0] poly_r [NUM_POLY];
  logic [CFG_DATA_BITS-1:0] poly_nxt [NUM_POLY];
  logic [DELAY_BITS-1:0]    delay_r, delay_nxt;

  // delay line control
  logic [AW-1:0] wp_r, wp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          act_r, act_nxt;
  logic [CW-1:0] cnt_eff;
  logic [DW-1:0] d_ext, d_eff;
  logic [PW-1:0] wp_p, d_p, ra_p;
  logic [AW-1:0] raddr;
  logic [SAMPLE_BITS-1:0] rdata;

  // states
  logic signed [SB-1:0] cs_r, cs_nxt;
  logic signed [SB-1:0] ds_r, ds_nxt;
  logic signed [SB-1:0] ol_r, ol_nxt;

  // datapath payload
  logic signed [SB-1:0] x_r, x_nxt;
  logic signed [SB-1:0] acc_r, acc_nxt;
  logic signed [SB-1:0] dec_r, dec_nxt;
  logic signed [SB-1:0] dso_r, dso_nxt;
  logic signed [SW-1:0] sum_r, sum_nxt;
  logic [SB-1:0]        argm_r, argm_nxt;
  logic                 args_r, args_nxt;
  logic [SB-1:0]        ua_r, ua_nxt;
  logic                 neg_r, neg_nxt;
  logic [SB+H-1:0]      pl_r, pl_nxt;
  logic [2*SB-1:0]      prod_r, prod_nxt;

  // output register
  logic                       out_valid_r, out_valid_nxt;
  logic signed [OUT_BITS-1:0] out_voltage_r, out_voltage_nxt;

  // combinational
  logic signed [SB-1:0]       xs, x_q, arg_v, coef_s;
  logic [CFG_DATA_BITS-1:0]   cword;
  logic [COEF_BITS-1:0]       coef16;
  logic [SB-1:0]              ua;
  logic [SB-1:0]              mul_a;
  logic [SB-H-1:0]            mul_b;
  logic [2*SB-H-1:0]          mul_p;
  logic [SB+H-1:0]            pl;
  logic [2*SB-H-1:0]          hp;
  logic [RW-1:0]              r_w;
  logic [SB-1:0]              lim_sb, rs;
  logic signed [SW-1:0]       c_w, rs_w, fin_v;
  logic signed [XW-1:0]       olx, omax, omin;
  logic signed [OUT_BITS-1:0] ovolt;

  assign cfg_ch.ready   = 1'b1;
  assign in_ch.ready    = (ctl.op == OP_IDLE);
  assign accept         = in_ch.valid && in_ch.ready;
  assign out_busy       = out_valid_r && !out_ch.ready;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.voltage = out_voltage_r;

  assign stat.accept   = accept;
  assign stat.active   = act_r;
  assign stat.out_busy = out_busy;

  nps_seq #(.POLY_TERMS(POLY_TERMS)) u_seq (
    .clk  (clk),
    .rst_n(rst_n),
    .stat (stat),
    .ctl  (ctl),
    .cidx (cidx)
  );

  nps_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_DELAY)) u_dly (
    .clk  (clk),
    .we   (accept),
    .waddr(wp_r),
    .wdata(in_ch.sample),
    .re   (accept),
    .raddr(raddr),
    .rdata(rdata)
  );

  // delay and sample count
  always_comb begin
    d_ext = DW'(delay_r);
    if (d_ext == '0) begin
      d_eff = DW'(1);
    end else if (d_ext > DW'(MAX_DELAY)) begin
      d_eff = DW'(MAX_DELAY);
    end else begin
      d_eff = d_ext;
    end
    cnt_eff = in_ch.first_sample ? '0 : cnt_r;
    active  = (DW'(cnt_eff) >= d_eff);
    wp_p    = PW'(wp_r);
    d_p     = PW'(d_eff);
    ra_p    = (wp_p >= d_p) ? wp_p - d_p : wp_p + PW'(MAX_DELAY) - d_p;
    raddr   = ra_p[AW-1:0];
  end

  // operand selection, coefficient and multiplier
  always_comb begin
    xs  = SB'(signed'(rdata));
    x_q = (xs <<< SH_L) >>> SH_R;

    case (ctl.arg)
      ARG_CS:  arg_v = cs_r;
      ARG_X:   arg_v = x_r;
      ARG_XMD: arg_v = sat_s(SW'(x_r) - SW'(ds_r));
      ARG_DEC: arg_v = dec_r;
      ARG_DD:  arg_v = sat_s(SW'(ds_r) - SW'(dso_r));
      ARG_OL:  arg_v = ol_r;
      default: arg_v = '0;
    endcase

    cword  = poly_r[ctl.poly];
    coef16 = cword[cidx*COEF_BITS +: COEF_BITS];
    coef_s = SB'(signed'({coef16, {COEF_SHIFT{1'b0}}}));

    // one multiplier: low half of the operand in MLO, high half in MHI
    ua    = mag_s(acc_r);
    mul_a = (ctl.op == OP_MHI) ? ua_r : ua;
    mul_b = (ctl.op == OP_MHI) ? argm_r[SB-1:H] : (SB-H)'(argm_r[H-1:0]);
    mul_p = mul_a * mul_b;
    pl    = mul_p[SB+H-1:0];
    hp    = mul_p;

    r_w    = prod_r[2*SB-1:Q_FRAC];
    lim_sb = {neg_r, {(SB-1){~neg_r}}};
    rs     = (r_w > RW'(lim_sb)) ? lim_sb : r_w[SB-1:0];
    c_w    = SW'(coef_s);
    rs_w   = signed'({2'b00, rs});
    fin_v  = neg_r ? c_w - rs_w : c_w + rs_w;

    olx  = XW'(ol_r);
    omax = XW'({1'b0, {(OUT_BITS-1){1'b1}}});
    omin = ~omax;
    if (olx > omax) begin
      ovolt = omax[OUT_BITS-1:0];
    end else if (olx < omin) begin
      ovolt = omin[OUT_BITS-1:0];
    end else begin
      ovolt = olx[OUT_BITS-1:0];
    end
  end

  // next-state
  always_comb begin
    poly_nxt        = poly_r;
    delay_nxt       = delay_r;
    wp_nxt          = wp_r;
    cnt_nxt         = cnt_r;
    act_nxt         = act_r;
    cs_nxt          = cs_r;
    ds_nxt          = ds_r;
    ol_nxt          = ol_r;
    x_nxt           = x_r;
    acc_nxt         = acc_r;
    dec_nxt         = dec_r;
    dso_nxt         = dso_r;
    sum_nxt         = sum_r;
    argm_nxt        = argm_r;
    args_nxt        = args_r;
    ua_nxt          = ua_r;
    neg_nxt         = neg_r;
    pl_nxt          = pl_r;
    prod_nxt        = prod_r;
    out_valid_nxt   = out_valid_r;
    out_voltage_nxt = out_voltage_r;

    if (cfg_ch.valid) begin
      if (cfg_ch.index < CFG_IDX_BITS'(NUM_POLY)) begin
        poly_nxt[cfg_ch.index] = cfg_ch.data;
      end else if (cfg_ch.index == REG_DELAY_BINS) begin
        delay_nxt = cfg_ch.data[DELAY_BITS-1:0];
      end
    end

    if (accept) begin
      wp_nxt  = (wp_r == AW'(MAX_DELAY - 1)) ? '0 : wp_r + AW'(1);
      cnt_nxt = (cnt_eff < CW'(MAX_DELAY)) ? cnt_eff + CW'(1) : cnt_eff;
      act_nxt = active;
      if (in_ch.first_sample) begin
        cs_nxt = '0;
        ds_nxt = '0;
        ol_nxt = '0;
      end
    end

    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (ctl.op)
      OP_XLOAD: x_nxt = x_q;
      OP_LOAD: begin
        acc_nxt  = coef_s;
        argm_nxt = mag_s(arg_v);
        args_nxt = arg_v[SB-1];
      end
      OP_MLO: begin
        ua_nxt  = ua;
        neg_nxt = acc_r[SB-1] ^ args_r;
        pl_nxt  = pl;
      end
      OP_MHI: prod_nxt = {hp, {H{1'b0}}} + (2*SB)'(pl_r);
      OP_FIN: acc_nxt = sat_s(fin_v);
      OP_USE: begin
        case (ctl.act)
          ACT_DEC: begin
            dec_nxt = acc_r;
            sum_nxt = SW'(cs_r) + SW'(acc_r);
          end
          ACT_CS: cs_nxt = sat_s(sum_r + SW'(acc_r));
          ACT_DS: begin
            dso_nxt = ds_r;
            ds_nxt  = sat_s(SW'(ds_r) + SW'(acc_r));
          end
          ACT_OS: sum_nxt = SW'(ol_r) + SW'(acc_r);
          ACT_OD: sum_nxt = sum_r + SW'(acc_r);
          ACT_OO: ol_nxt  = sat_s(sum_r + SW'(acc_r));
          default: ;
        endcase
      end
      OP_EMIT: begin
        if (!out_busy) begin
          out_valid_nxt   = 1'b1;
          out_voltage_nxt = act_r ? ovolt : '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_POLY; i++) begin
        poly_r[i] <= '0;
      end
      delay_r     <= DELAY_BITS'(1);
      wp_r        <= '0;
      cnt_r       <= '0;
      act_r       <= 1'b0;
      cs_r        <= '0;
      ds_r        <= '0;
      ol_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      poly_r      <= poly_nxt;
      delay_r     <= delay_nxt;
      wp_r        <= wp_nxt;
      cnt_r       <= cnt_nxt;
      act_r       <= act_nxt;
      cs_r        <= cs_nxt;
      ds_r        <= ds_nxt;
      ol_r        <= ol_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r           <= x_nxt;
    acc_r         <= acc_nxt;
    dec_r         <= dec_nxt;
    dso_r         <= dso_nxt;
    sum_r         <= sum_nxt;
    argm_r        <= argm_nxt;
    args_r        <= args_nxt;
    ua_r          <= ua_nxt;
    neg_r         <= neg_nxt;
    pl_r          <= pl_nxt;
    prod_r        <= prod_nxt;
    out_voltage_r <= out_voltage_nxt;
  end

endmodule
